[rtl/core/tty_receive_fifo_with_dma_drain_core_macros.svh]
// Assertion macros for the serial terminal receive core.
// Clocked on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef TTY_RECEIVE_FIFO_WITH_DMA_DRAIN_CORE_MACROS_SVH
`define TTY_RECEIVE_FIFO_WITH_DMA_DRAIN_CORE_MACROS_SVH

// Check a property at every clock edge out of reset.
`define TTYRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define TTYRX_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/ttyrx_pkg.sv]
// Shared types and constants for the serial terminal receive core.
// No dependencies; used by the top level.
package ttyrx_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned QA_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QF_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W       = QA_W + 1;
  localparam int unsigned MAX_BEATS   = 32;
  localparam int unsigned MAX_DRAIN   = 4 * MAX_BEATS;
  localparam int unsigned RM_W        = $clog2(MAX_DRAIN + 1);

  localparam logic [QF_W-1:0]  QDEPTH_F = QF_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] QDEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [QA_W-1:0]  QLAST_A  = QA_W'(QUEUE_DEPTH - 1);

  localparam logic [31:0] DEVICE_VERSION = 32'd1;

  localparam logic [11:0] OFS_PUT      = 12'h000;
  localparam logic [11:0] OFS_READY    = 12'h004;
  localparam logic [11:0] OFS_CMD      = 12'h008;
  localparam logic [11:0] OFS_PTR      = 12'h010;
  localparam logic [11:0] OFS_LEN      = 12'h014;
  localparam logic [11:0] OFS_PTR_HIGH = 12'h018;
  localparam logic [11:0] OFS_VERSION  = 12'h020;

  localparam logic [31:0] CMD_IRQ_OFF = 32'd0;
  localparam logic [31:0] CMD_IRQ_ON  = 32'd1;
  localparam logic [31:0] CMD_TX_BUF  = 32'd2;
  localparam logic [31:0] CMD_RX_BUF  = 32'd3;

  localparam int unsigned CFG_AW        = 3;
  localparam logic        CFG_CONNECTED = 1'b0;
  localparam logic        CFG_SIGN_EXT  = 1'b1;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RX    = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_ACK  = 3'd0,
    KIND_READ = 3'd1,
    KIND_TX   = 3'd2,
    KIND_BEAT = 3'd3,
    KIND_ERR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RD_OFS   = 3'd1,
    ERR_WR_OFS   = 3'd2,
    ERR_CMD      = 3'd3,
    ERR_OVERREAD = 3'd4,
    ERR_OVERFLOW = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_REQ,
    ST_RD_CAP,
    ST_OUT
  } state_e;

endpackage

[rtl/core/ttyrx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the receive queue bytes.
module ttyrx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tty_receive_fifo_with_dma_drain_core.sv]
// Serial terminal core: register access, receive queue and drain to memory beats.
// Depends on ttyrx_pkg, ttyrx_ram and the assertion macro header.
//
//   channel | direction | handshake                | contents
//   --------+-----------+--------------------------+---------------------------------------
//   in      | to core   | in_valid_i / in_ready_o  | func, reg_offset, write_value, rx_byte
//   out     | from core | out_valid_o / out_ready_i| kind, read data, tx byte, beat, error
//   apb     | to core   | psel, penable, pwrite    | port_connected @0x0, sign extend @0x4
//
// A single-result item is accepted, executed and then presented as the result.
// A drain reads each byte with a request step and a capture step and hands out each beat;
// the one read port of the queue RAM and the single byte lane that packs beats set this pace.
// Reset is asynchronous active low and clears all control state; no clearing pass.
// A stalled result holds the block; no new word is taken until the item's last
// result has been accepted.
`include "tty_receive_fifo_with_dma_drain_core_macros.svh"

module tty_receive_fifo_with_dma_drain_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            func_i,
  input  logic [11:0]           reg_offset_i,
  input  logic [31:0]           write_value_i,
  input  logic [7:0]            rx_byte_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ttyrx_pkg::kind_e      kind_o,
  output logic [31:0]           read_data_o,
  output logic [7:0]            tx_byte_o,
  output logic [63:0]           dma_address_o,
  output logic [31:0]           dma_data_o,
  output logic [2:0]            dma_byte_count_o,
  output ttyrx_pkg::err_e       error_code_o,
  output logic                  irq_o,
  output logic                  last_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ttyrx_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import ttyrx_pkg::*;

  state_e state_q, state_d;

  // latched item
  func_e       func_q, func_d;
  logic [11:0] ofs_q, ofs_d;
  logic [31:0] val_q, val_d;
  logic [7:0]  byte_q, byte_d;

  // configuration
  logic connected_q, sext_q;

  // device state
  logic            irq_en_q, irq_en_d;
  logic [QA_W-1:0] head_q, head_d;
  logic [QF_W-1:0] fill_q, fill_d;
  logic [63:0]     ptr_q, ptr_d;
  logic [31:0]     len_q, len_d;

  // drain sequencer
  logic [RM_W-1:0] rem_q, rem_d;
  logic [1:0]      bidx_q, bidx_d;
  logic [63:0]     addr_q, addr_d;
  logic [31:0]     word_q, word_d;

  // result register
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [31:0] rdata_q, rdata_d;
  logic [7:0]  tx_q, tx_d;
  logic [63:0] daddr_q, daddr_d;
  logic [31:0] ddata_q, ddata_d;
  logic [2:0]  dcnt_q, dcnt_d;
  err_e        err_q, err_d;
  logic        irq_q, irq_d;
  logic        last_q, last_d;

  // queue RAM
  logic             ram_we;
  logic [QA_W-1:0]  ram_waddr;
  logic [7:0]       ram_rdata;
  logic [SUM_W-1:0] tail_sum;
  logic [QA_W-1:0]  head_inc;
  logic [2:0]       beat_len;
  logic [31:0]      word_nxt;
  logic             new_en;
  logic [QF_W-1:0]  new_fill;

  ttyrx_ram #(
    .Width (8),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_q),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_SIGN_EXT) ? {31'd0, sext_q} : {31'd0, connected_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q <= 1'b1;
      sext_q      <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == CFG_SIGN_EXT) begin
        sext_q <= pwdata[0];
      end else begin
        connected_q <= pwdata[0];
      end
    end
  end

  // queue position arithmetic
  assign tail_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
  assign ram_waddr = (tail_sum >= QDEPTH_S) ? QA_W'(tail_sum - QDEPTH_S) : QA_W'(tail_sum);
  assign head_inc  = (head_q == QLAST_A) ? '0 : head_q + QA_W'(1);
  assign beat_len  = (rem_q >= RM_W'(4)) ? 3'd4 : rem_q[2:0];

  always_comb begin
    word_nxt = word_q;
    word_nxt[8*bidx_q +: 8] = ram_rdata;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    ofs_d       = ofs_q;
    val_d       = val_q;
    byte_d      = byte_q;
    irq_en_d    = irq_en_q;
    head_d      = head_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    len_d       = len_q;
    rem_d       = rem_q;
    bidx_d      = bidx_q;
    addr_d      = addr_q;
    word_d      = word_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    rdata_d     = rdata_q;
    tx_d        = tx_q;
    daddr_d     = daddr_q;
    ddata_d     = ddata_q;
    dcnt_d      = dcnt_q;
    err_d       = err_q;
    irq_d       = irq_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    new_en      = irq_en_q;
    new_fill    = fill_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_e'(func_i);
          ofs_d   = reg_offset_i;
          val_d   = write_value_i;
          byte_d  = rx_byte_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        kind_d      = KIND_ACK;
        rdata_d     = '0;
        tx_d        = '0;
        daddr_d     = '0;
        ddata_d     = '0;
        dcnt_d      = '0;
        err_d       = ERR_NONE;
        last_d      = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_OUT;
        case (func_q)
          FUNC_READ: begin
            if (ofs_q == OFS_READY) begin
              kind_d  = KIND_READ;
              rdata_d = 32'(fill_q);
            end else if (ofs_q == OFS_VERSION) begin
              kind_d  = KIND_READ;
              rdata_d = DEVICE_VERSION;
            end else begin
              kind_d = KIND_ERR;
              err_d  = ERR_RD_OFS;
            end
          end
          FUNC_WRITE: begin
            case (ofs_q)
              OFS_PUT: begin
                if (connected_q) begin
                  kind_d = KIND_TX;
                  tx_d   = val_q[7:0];
                end
              end
              OFS_CMD: begin
                case (val_q)
                  CMD_IRQ_OFF: new_en = 1'b0;
                  CMD_IRQ_ON:  new_en = 1'b1;
                  CMD_TX_BUF:  new_en = irq_en_q;
                  CMD_RX_BUF: begin
                    if (len_q > 32'(fill_q) || len_q > 32'(MAX_DRAIN)) begin
                      kind_d = KIND_ERR;
                      err_d  = ERR_OVERREAD;
                    end else if (len_q != 32'd0) begin
                      // start the drain; fill drops by the whole length up front
                      out_valid_d = 1'b0;
                      state_d     = ST_RD_REQ;
                      rem_d       = RM_W'(len_q);
                      new_fill    = fill_q - QF_W'(len_q);
                      addr_d      = ptr_q;
                      bidx_d      = '0;
                      word_d      = '0;
                    end
                  end
                  default: begin
                    kind_d = KIND_ERR;
                    err_d  = ERR_CMD;
                  end
                endcase
              end
              OFS_PTR: begin
                if (sext_q) begin
                  ptr_d = {{32{val_q[31]}}, val_q};
                end else begin
                  ptr_d = {ptr_q[63:32], val_q};
                end
              end
              OFS_PTR_HIGH: ptr_d = {val_q, ptr_q[31:0]};
              OFS_LEN:      len_d = val_q;
              default: begin
                kind_d = KIND_ERR;
                err_d  = ERR_WR_OFS;
              end
            endcase
          end
          FUNC_RX: begin
            if (connected_q) begin
              if (fill_q >= QDEPTH_F) begin
                kind_d = KIND_ERR;
                err_d  = ERR_OVERFLOW;
              end else begin
                ram_we   = 1'b1;
                new_fill = fill_q + QF_W'(1);
              end
            end
          end
          default: begin
            kind_d = KIND_ACK;
          end
        endcase
        irq_en_d = new_en;
        fill_d   = new_fill;
        irq_d    = new_en && (new_fill != '0);
      end

      ST_RD_REQ: begin
        // RAM address is head_q; data arrives next cycle
        state_d = ST_RD_CAP;
      end

      ST_RD_CAP: begin
        head_d = head_inc;
        if ({1'b0, bidx_q} == beat_len - 3'd1) begin
          kind_d      = KIND_BEAT;
          rdata_d     = '0;
          tx_d        = '0;
          daddr_d     = addr_q;
          ddata_d     = word_nxt;
          dcnt_d      = beat_len;
          err_d       = ERR_NONE;
          last_d      = (rem_q == RM_W'(beat_len));
          out_valid_d = 1'b1;
          rem_d       = rem_q - RM_W'(beat_len);
          addr_d      = addr_q + 64'd4;
          bidx_d      = '0;
          word_d      = '0;
          state_d     = ST_OUT;
        end else begin
          word_d  = word_nxt;
          bidx_d  = bidx_q + 2'd1;
          state_d = ST_RD_REQ;
        end
      end

      ST_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = last_q ? ST_IDLE : ST_RD_REQ;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      irq_en_q    <= 1'b0;
      head_q      <= '0;
      fill_q      <= '0;
      ptr_q       <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      bidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      irq_en_q    <= irq_en_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      bidx_q      <= bidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    ofs_q   <= ofs_d;
    val_q   <= val_d;
    byte_q  <= byte_d;
    addr_q  <= addr_d;
    word_q  <= word_d;
    kind_q  <= kind_d;
    rdata_q <= rdata_d;
    tx_q    <= tx_d;
    daddr_q <= daddr_d;
    ddata_q <= ddata_d;
    dcnt_q  <= dcnt_d;
    err_q   <= err_d;
    irq_q   <= irq_d;
    last_q  <= last_d;
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign read_data_o      = rdata_q;
  assign tx_byte_o        = tx_q;
  assign dma_address_o    = daddr_q;
  assign dma_data_o       = ddata_q;
  assign dma_byte_count_o = dcnt_q;
  assign error_code_o     = err_q;
  assign irq_o            = irq_q;
  assign last_o           = last_q;

  `TTYRX_ASSERT(a_ready_no_pending, in_ready_o |-> !out_valid_o, "word taken while result pending")
  `TTYRX_ASSERT(a_fill_bound, fill_q <= QDEPTH_F, "queue fill beyond depth")
  `TTYRX_ASSERT(a_beat_count, (out_valid_o && kind_o == KIND_BEAT) |-> (dma_byte_count_o != 3'd0 && dma_byte_count_o <= 3'd4), "bad beat byte count")
  `TTYRX_ASSERT(a_nonbeat_count, (out_valid_o && kind_o != KIND_BEAT) |-> (dma_byte_count_o == 3'd0), "byte count on non-beat result")
  `TTYRX_ASSERT_NEXT(a_more_after_mid, out_valid_o && out_ready_i && !last_o, !in_ready_o, "item ended before last result")

endmodule

[verif/tb_tty_receive_fifo_with_dma_drain_core.sv]
// Testbench for the serial terminal receive core: register map, receive queue, drain beats.
// Predicts every result in its own model and checks the output channel word by word.
// Depends on ttyrx_pkg and the tty_receive_fifo_with_dma_drain_core RTL.
module tb_tty_receive_fifo_with_dma_drain_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ttyrx_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_SLACK = 20;
  localparam int unsigned CFG_SETTLE  = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [CFG_AW-1:0] ADDR_CONNECTED = CFG_AW'(4 * int'(CFG_CONNECTED));
  localparam logic [CFG_AW-1:0] ADDR_SIGN_EXT  = CFG_AW'(4 * int'(CFG_SIGN_EXT));

  typedef struct {
    kind_e       kind;
    logic [31:0] read_data;
    logic [7:0]  tx_byte;
    logic [63:0] dma_address;
    logic [31:0] dma_data;
    logic [2:0]  dma_byte_count;
    err_e        error_code;
    logic        irq;
    logic        last;
  } tty_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        func_i = '0;
  logic [11:0]       reg_offset_i = '0;
  logic [31:0]       write_value_i = '0;
  logic [7:0]        rx_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  kind_e             kind_o;
  logic [31:0]       read_data_o;
  logic [7:0]        tx_byte_o;
  logic [63:0]       dma_address_o;
  logic [31:0]       dma_data_o;
  logic [2:0]        dma_byte_count_o;
  err_e              error_code_o;
  logic              irq_o;
  logic              last_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predicted device state
  logic [7:0]      rxq_mem [QUEUE_DEPTH];
  logic [QA_W-1:0] rxq_head = '0;
  logic [QF_W-1:0] rxq_fill = '0;
  logic            irq_on = 1'b0;
  logic [63:0]     dma_ptr = '0;
  logic [31:0]     dma_len = '0;
  logic            port_up = 1'b1;
  logic            ptr_sign_ext = 1'b0;

  tty_result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned hold_off_left = 0;
  bit          quiet = 1'b0;

  tty_receive_fifo_with_dma_drain_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .reg_offset_i     (reg_offset_i),
    .write_value_i    (write_value_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .read_data_o      (read_data_o),
    .tx_byte_o        (tx_byte_o),
    .dma_address_o    (dma_address_o),
    .dma_data_o       (dma_data_o),
    .dma_byte_count_o (dma_byte_count_o),
    .error_code_o     (error_code_o),
    .irq_o            (irq_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    foreach (rxq_mem[i]) rxq_mem[i] = '0;
  end

  function automatic tty_result_t blank_result(kind_e k);
    tty_result_t r;
    r.kind           = k;
    r.read_data      = '0;
    r.tx_byte        = '0;
    r.dma_address    = '0;
    r.dma_data       = '0;
    r.dma_byte_count = '0;
    r.error_code     = ERR_NONE;
    r.irq            = 1'b0;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic tty_result_t error_result(err_e code);
    tty_result_t r;
    r = blank_result(KIND_ERR);
    r.error_code = code;
    return r;
  endfunction

  // Advance the predicted state by one word and queue the results it causes.
  function automatic void predict_word(func_e fn, logic [11:0] ofs, logic [31:0] val,
                                       logic [7:0] b);
    tty_result_t res[$];
    tty_result_t r;
    logic [31:0] word;
    logic [31:0] done;
    logic [31:0] cnt;
    int          i;
    case (fn)
      FUNC_READ: begin
        if (ofs == OFS_READY) begin
          r = blank_result(KIND_READ);
          r.read_data = 32'(rxq_fill);
        end else if (ofs == OFS_VERSION) begin
          r = blank_result(KIND_READ);
          r.read_data = DEVICE_VERSION;
        end else begin
          r = error_result(ERR_RD_OFS);
        end
        res.push_back(r);
      end
      FUNC_WRITE: begin
        r = blank_result(KIND_ACK);
        case (ofs)
          OFS_PUT: begin
            if (port_up) begin
              r = blank_result(KIND_TX);
              r.tx_byte = val[7:0];
            end
          end
          OFS_CMD: begin
            case (val)
              CMD_IRQ_OFF: irq_on = 1'b0;
              CMD_IRQ_ON:  irq_on = 1'b1;
              CMD_TX_BUF:  ;
              CMD_RX_BUF: begin
                if (dma_len > 32'(rxq_fill) || dma_len > MAX_DRAIN) begin
                  r = error_result(ERR_OVERREAD);
                end else if (dma_len != 0) begin
                  done = 0;
                  while (done < dma_len) begin
                    cnt  = (dma_len - done > 4) ? 32'd4 : dma_len - done;
                    word = '0;
                    for (i = 0; i < int'(cnt); i++) begin
                      word[8*i +: 8] = rxq_mem[rxq_head];
                      rxq_head++;
                    end
                    r = blank_result(KIND_BEAT);
                    r.dma_address    = dma_ptr + 64'(done);
                    r.dma_data       = word;
                    r.dma_byte_count = 3'(cnt);
                    res.push_back(r);
                    done += cnt;
                  end
                  rxq_fill -= QF_W'(dma_len);
                end
              end
              default: r = error_result(ERR_CMD);
            endcase
          end
          OFS_PTR: begin
            if (ptr_sign_ext) dma_ptr = {{32{val[31]}}, val};
            else dma_ptr = {dma_ptr[63:32], val};
          end
          OFS_PTR_HIGH: dma_ptr = {val, dma_ptr[31:0]};
          OFS_LEN:      dma_len = val;
          default:      r = error_result(ERR_WR_OFS);
        endcase
        // a successful drain leaves its beats and no acknowledge
        if (res.size() == 0) res.push_back(r);
      end
      FUNC_RX: begin
        if (!port_up) begin
          r = blank_result(KIND_ACK);
        end else if (rxq_fill >= QDEPTH_F) begin
          r = error_result(ERR_OVERFLOW);
        end else begin
          rxq_mem[QA_W'(rxq_head + rxq_fill)] = b;
          rxq_fill++;
          r = blank_result(KIND_ACK);
        end
        res.push_back(r);
      end
      default: res.push_back(blank_result(KIND_ACK));
    endcase
    foreach (res[k]) begin
      res[k].irq  = irq_on && (rxq_fill != 0);
      res[k].last = (k == res.size() - 1);
      pending_results.push_back(res[k]);
    end
  endfunction

  task automatic send_word(func_e fn, logic [11:0] ofs, logic [31:0] val, logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    reg_offset_i  <= ofs;
    write_value_i <= val;
    rx_byte_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(fn, ofs, val, b);
  endtask

  // Drop valid and hold until the last expected word has been taken.
  task automatic wait_results(int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic val);
    wait_results(CFG_SETTLE);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_CONNECTED) port_up = val;
    else ptr_sign_ext = val;
    // read back in the same transfer sequence
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(val)) begin
      $error("prdata: expected 0x%0h, got 0x%0h", 32'(val), prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_register_map();
    send_word(FUNC_READ, OFS_VERSION, '0, '0);
    send_word(FUNC_READ, OFS_READY, '0, '0);
    send_word(FUNC_READ, OFS_PUT, '0, '0);
    send_word(FUNC_READ, 12'hFFF, '1, '1);
    send_word(FUNC_WRITE, OFS_READY, '0, '0);
    send_word(FUNC_WRITE, 12'hFFF, '1, '1);
    send_word(FUNC_WRITE, OFS_PUT, 32'hFFFF_FFFF, '0);
    send_word(FUNC_WRITE, OFS_PUT, 32'h0000_0000, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_TX_BUF, '0);
    send_word(FUNC_WRITE, OFS_CMD, 32'hFFFF_FFFF, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF + 32'd1, '0);
    send_word(FUNC_NONE, '1, '1, '1);
  endtask

  task automatic test_basic_drain();
    send_word(FUNC_WRITE, OFS_CMD, CMD_IRQ_ON, '0);
    send_word(FUNC_RX, '0, '0, 8'hA5);
    send_word(FUNC_RX, '0, '0, 8'h00);
    send_word(FUNC_RX, '0, '0, 8'hFF);
    send_word(FUNC_RX, '0, '0, 8'h3C);
    send_word(FUNC_RX, '0, '0, 8'h81);
    // place the buffer just below the top of memory so the beat address wraps
    send_word(FUNC_WRITE, OFS_PTR_HIGH, 32'hFFFF_FFFF, '0);
    send_word(FUNC_WRITE, OFS_PTR, 32'hFFFF_FFFE, '0);
    send_word(FUNC_WRITE, OFS_LEN, 32'd0, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, '0);
    send_word(FUNC_WRITE, OFS_LEN, 32'd6, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, '0);
    send_word(FUNC_WRITE, OFS_LEN, 32'd5, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, '0);
    send_word(FUNC_READ, OFS_READY, '0, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_IRQ_OFF, '0);
  endtask

  task automatic test_disconnected();
    cfg_write(ADDR_CONNECTED, 1'b0);
    send_word(FUNC_RX, '0, '0, 8'h5A);
    send_word(FUNC_WRITE, OFS_PUT, 32'h55, '0);
    send_word(FUNC_READ, OFS_READY, '0, '0);
    cfg_write(ADDR_CONNECTED, 1'b1);
  endtask

  task automatic test_sign_extend();
    cfg_write(ADDR_SIGN_EXT, 1'b1);
    repeat (4) send_word(FUNC_RX, '0, '0, 8'($urandom));
    send_word(FUNC_WRITE, OFS_PTR, 32'h8000_0000, '0);
    send_word(FUNC_WRITE, OFS_LEN, 32'd4, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, '0);
    repeat (2) send_word(FUNC_RX, '0, '0, 8'($urandom));
    send_word(FUNC_WRITE, OFS_PTR, 32'h7FFF_FFF0, '0);
    send_word(FUNC_WRITE, OFS_LEN, 32'd2, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, '0);
    cfg_write(ADDR_SIGN_EXT, 1'b0);
  endtask

  // Stall the receiver while bytes keep coming, overflow the queue, then drain it whole.
  task automatic test_full_queue();
    int unsigned fill_count;
    fill_count = QUEUE_DEPTH - rxq_fill + 2;
    hold_off_left = HOLD_CYCLES;
    repeat (fill_count) send_word(FUNC_RX, 12'($urandom), $urandom, 8'($urandom));
    wait_results(0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_IRQ_ON, '0);
    send_word(FUNC_WRITE, OFS_PTR, $urandom, '0);
    send_word(FUNC_WRITE, OFS_LEN, MAX_DRAIN + 1, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, '0);
    send_word(FUNC_WRITE, OFS_LEN, MAX_DRAIN, '0);
    send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, '0);
    send_word(FUNC_READ, OFS_READY, '0, '0);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned k;
    logic [31:0] len;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        k = $urandom_range(1, 12);
        repeat (k) send_word(FUNC_RX, 12'($urandom), $urandom, 8'($urandom));
        sent += k;
      end else if (pick < 60) begin
        if ($urandom_range(0, 1) == 0) begin
          send_word(FUNC_WRITE, OFS_PTR, $urandom, 8'($urandom));
          sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
          send_word(FUNC_WRITE, OFS_PTR_HIGH, $urandom, 8'($urandom));
          sent++;
        end
        if (pick == 59) len = $urandom;
        else if ($urandom_range(0, 7) == 0) len = 32'(rxq_fill) + $urandom_range(1, 3);
        else len = $urandom_range(0, int'(rxq_fill));
        send_word(FUNC_WRITE, OFS_LEN, len, 8'($urandom));
        send_word(FUNC_WRITE, OFS_CMD, CMD_RX_BUF, 8'($urandom));
        sent += 2;
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0:       send_word(FUNC_READ, OFS_READY, $urandom, 8'($urandom));
          1:       send_word(FUNC_READ, OFS_VERSION, $urandom, 8'($urandom));
          default: send_word(FUNC_READ, 12'($urandom), $urandom, 8'($urandom));
        endcase
        sent++;
      end else if (pick < 90) begin
        case ($urandom_range(0, 5))
          0:       send_word(FUNC_WRITE, OFS_PUT, $urandom, 8'($urandom));
          1:       send_word(FUNC_WRITE, OFS_CMD, CMD_IRQ_OFF, 8'($urandom));
          2:       send_word(FUNC_WRITE, OFS_CMD, CMD_IRQ_ON, 8'($urandom));
          3:       send_word(FUNC_WRITE, OFS_CMD, CMD_TX_BUF, 8'($urandom));
          4:       send_word(FUNC_WRITE, OFS_CMD, $urandom, 8'($urandom));
          default: send_word(FUNC_WRITE, 12'($urandom), $urandom, 8'($urandom));
        endcase
        sent++;
      end else begin
        send_word(func_e'($urandom_range(0, 3)), 12'($urandom), $urandom, 8'($urandom));
        sent++;
      end
    end
  endtask

  // Receiver: random ready bursts, long hold-off on request, always ready when quiet.
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left != 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (run_left != 0) begin
        out_ready_i <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b1;
        run_left = $urandom_range(0, 24);
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    tty_result_t r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected output word: kind 0x%0h", kind_o);
          errors++;
        end else begin
          r = pending_results.pop_front();
          check_field("kind", 64'(r.kind), 64'(kind_o));
          check_field("read_data", 64'(r.read_data), 64'(read_data_o));
          check_field("tx_byte", 64'(r.tx_byte), 64'(tx_byte_o));
          check_field("dma_address", r.dma_address, dma_address_o);
          check_field("dma_data", 64'(r.dma_data), 64'(dma_data_o));
          check_field("dma_byte_count", 64'(r.dma_byte_count), 64'(dma_byte_count_o));
          check_field("error_code", 64'(r.error_code), 64'(error_code_o));
          check_field("irq", 64'(r.irq), 64'(irq_o));
          check_field("last", 64'(r.last), 64'(last_o));
        end
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_map();
    test_basic_drain();
    test_disconnected();
    test_sign_extend();
    test_full_queue();
    test_random(35);
    cfg_write(ADDR_SIGN_EXT, 1'b1);
    test_random(30);
    cfg_write(ADDR_CONNECTED, 1'b0);
    test_random(10);
    cfg_write(ADDR_CONNECTED, 1'b1);
    cfg_write(ADDR_SIGN_EXT, 1'b0);
    quiet = 1'b1;
    test_random(25);
    wait_results(DRAIN_SLACK);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
